/* rtl/fhpe_pkg.sv */
// ----------------------------------------------------------------------------
// fhpe_pkg: shared types and constants of the fade/hold/pulse envelope
// Level format, duration width, phase, kind, mode and register codes.
// ----------------------------------------------------------------------------
package fhpe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LVL_W     = FRAC_BITS + 1;
    localparam int DUR_W     = 24;
    localparam int DELTA_W   = 16;

    typedef logic [LVL_W-1:0] level_t;
    typedef logic [DUR_W-1:0] dur_t;
    typedef logic [1:0]       code_t;

    localparam level_t ONE_LVL = {1'b1, {FRAC_BITS{1'b0}}};

    localparam dur_t ENTER_TIME_RST   = 24'd200000;
    localparam dur_t EXIT_TIME_RST    = 24'd150000;
    localparam dur_t PULSE_PERIOD_RST = 24'd1000000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam code_t PH_INACTIVE = 2'd0;
    localparam code_t PH_ENTER    = 2'd1;
    localparam code_t PH_HOLD     = 2'd2;
    localparam code_t PH_EXIT     = 2'd3;

    localparam code_t KIND_NONE  = 2'd0;
    localparam code_t KIND_VALID = 2'd1;
    localparam code_t KIND_OTHER = 2'd2;

    localparam code_t MODE_TICK   = 2'd0;
    localparam code_t MODE_BEGIN  = 2'd1;
    localparam code_t MODE_EXIT   = 2'd2;
    localparam code_t MODE_IGNORE = 2'd3;

    localparam code_t CFG_ENTER_TIME     = 2'd0;
    localparam code_t CFG_EXIT_TIME      = 2'd1;
    localparam code_t CFG_PULSE_PERIOD   = 2'd2;
    localparam code_t CFG_REDUCED_MOTION = 2'd3;

endpackage

/* rtl/fhpe_divider.sv */
// ----------------------------------------------------------------------------
// fhpe_divider: shared restoring divider
// One quotient bit per cycle; quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module fhpe_divider #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, acc_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            acc_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = acc_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/fhpe_sine_rom.sv */
// ----------------------------------------------------------------------------
// fhpe_sine_rom: quarter-wave sine table
// Entries 0..DEPTH of sin(pi/2 * i / DEPTH) as levels, registered read.
// ----------------------------------------------------------------------------
module fhpe_sine_rom #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH+1)-1:0] addr,
    output fhpe_pkg::level_t         data
);

    function automatic fhpe_pkg::level_t sine_level(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        longint unsigned v;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        term = ((term * x2) >> 30) / 6;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 20;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 42;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 72;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 110;
        neg  = neg + term;
        term = ((term * x2) >> 30) / 156;
        pos  = pos + term;
        term = ((term * x2) >> 30) / 210;
        neg  = neg + term;
        s = (pos > neg) ? (pos - neg) : 64'd0;
        v = (s + (64'd1 << (29 - fhpe_pkg::FRAC_BITS))) >> (30 - fhpe_pkg::FRAC_BITS);
        if (v > 64'(fhpe_pkg::ONE_LVL))
        begin
            v = 64'(fhpe_pkg::ONE_LVL);
        end
        return fhpe_pkg::LVL_W'(v);
    endfunction

    fhpe_pkg::level_t tab [0:DEPTH];
    fhpe_pkg::level_t data_reg;

    for (genvar i = 0; i <= DEPTH; i++)
    begin : g_entry
        localparam longint unsigned X = (fhpe_pkg::HALF_PI_Q30 * 64'(i)) / DEPTH;
        assign tab[i] = sine_level(X);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= tab[addr];
    end

    assign data = data_reg;

endmodule

/* rtl/fade_hold_pulse_envelope.sv */
// ----------------------------------------------------------------------------
// fade_hold_pulse_envelope: entering / holding / exiting intensity envelope
// Begin, exit, ignored items and ticks while inactive go straight to the
// result stage; an entering or exiting tick short of its duration waits
// on the bit-serial divider, and a holding tick with pulse uses it twice.
// One transaction at a time; the next is taken as soon as the result is
// registered. Reset: envelope inactive, registers at their default values.
// ----------------------------------------------------------------------------
module fade_hold_pulse_envelope #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int TIME_BITS        = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [1:0]                    mode,
    input  logic [1:0]                    kind,
    input  logic [fhpe_pkg::DELTA_W-1:0]  elapsed_delta,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          active,
    output logic [1:0]                    shown_kind,
    output logic [1:0]                    phase,
    output fhpe_pkg::level_t              amount,
    output fhpe_pkg::level_t              pulse,
    output logic                          started,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [fhpe_pkg::DUR_W-1:0]    cfg_data
);

    localparam int FRAC      = fhpe_pkg::FRAC_BITS;
    localparam int LVL_W     = fhpe_pkg::LVL_W;
    localparam int DUR_W     = fhpe_pkg::DUR_W;
    localparam int TW        = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam int IDX_W     = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int IDX_MUL_W = $clog2(4 * SINE_TABLE_DEPTH + 1);
    localparam int NUM_W     = ((DUR_W + FRAC) > (DUR_W + IDX_MUL_W)) ?
                               (DUR_W + FRAC) : (DUR_W + IDX_MUL_W);
    localparam int ROM_AW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W    = 2 * LVL_W;

    localparam logic [IDX_MUL_W-1:0] SPAN4 = IDX_MUL_W'(4 * SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0]     SPAN1 = IDX_W'(SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0]     SPAN2 = IDX_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0]     SPAN3 = IDX_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_TICK  = 12'b0000_0000_0010,
        S_ALPHA = 12'b0000_0000_0100,
        S_MUL_A = 12'b0000_0000_1000,
        S_MUL_B = 12'b0000_0001_0000,
        S_MUL_C = 12'b0000_0010_0000,
        S_APPLY = 12'b0000_0100_0000,
        S_MOD   = 12'b0000_1000_0000,
        S_IDX   = 12'b0001_0000_0000,
        S_ROM   = 12'b0010_0000_0000,
        S_PULSE = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t                state_reg, state_next;

    fhpe_pkg::dur_t        cfg_enter_reg, cfg_enter_next;
    fhpe_pkg::dur_t        cfg_exit_reg, cfg_exit_next;
    fhpe_pkg::dur_t        cfg_period_reg, cfg_period_next;
    logic                  cfg_rm_reg, cfg_rm_next;
    fhpe_pkg::dur_t        lat_enter_reg, lat_enter_next;
    fhpe_pkg::dur_t        lat_exit_reg, lat_exit_next;
    fhpe_pkg::dur_t        lat_period_reg, lat_period_next;
    logic                  lat_rm_reg, lat_rm_next;

    fhpe_pkg::code_t       phase_reg, phase_next;
    logic                  active_reg, active_next;
    fhpe_pkg::code_t       kind_reg, kind_next;
    logic [TIME_BITS-1:0]  phase_time_reg, phase_time_next;
    fhpe_pkg::dur_t        hold_time_reg, hold_time_next;
    fhpe_pkg::level_t      start_amount_reg, start_amount_next;
    fhpe_pkg::level_t      amount_reg, amount_next;
    fhpe_pkg::level_t      pulse_reg, pulse_next;
    logic                  started_reg, started_next;
    logic                  result_valid_reg, result_valid_next;

    logic [fhpe_pkg::DELTA_W-1:0] delta_reg, delta_next;
    fhpe_pkg::level_t      alpha_reg, alpha_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    logic                  res_active_reg;
    fhpe_pkg::code_t       res_kind_reg;
    fhpe_pkg::code_t       res_phase_reg;
    fhpe_pkg::level_t      res_amount_reg;
    fhpe_pkg::level_t      res_pulse_reg;
    logic                  res_started_reg;
    logic                  res_load;

    logic                  accept;
    fhpe_pkg::code_t       kind_m;
    logic                  do_exit;
    logic                  same_kind;
    logic [TIME_BITS:0]    pt_sum;
    logic [TIME_BITS-1:0]  pt_sat;
    logic [TW-1:0]         pt_ext;
    fhpe_pkg::dur_t        dur_cur;
    logic                  reached;
    logic                  in_enter;
    logic                  pulse_on;
    fhpe_pkg::level_t      prod_hi;
    fhpe_pkg::level_t      om;
    logic [DUR_W:0]        hold_sum;

    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    fhpe_pkg::dur_t        div_den;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quot;
    fhpe_pkg::dur_t        div_rem;

    fhpe_pkg::level_t      mul_a;
    fhpe_pkg::level_t      mul_b;

    logic [1:0]            quad;
    logic [IDX_W-1:0]      rem_idx;
    logic [ROM_AW-1:0]     rom_addr;
    fhpe_pkg::level_t      rom_data;
    logic [LVL_W:0]        pulse_up;
    fhpe_pkg::level_t      pulse_dn;
    fhpe_pkg::level_t      pulse_val;

    fhpe_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DUR_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    fhpe_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign kind_m = (kind != fhpe_pkg::KIND_NONE && kind != fhpe_pkg::KIND_VALID) ?
                    fhpe_pkg::KIND_OTHER : kind;
    assign do_exit = (mode == fhpe_pkg::MODE_EXIT) ||
                     (mode == fhpe_pkg::MODE_BEGIN && kind_m == fhpe_pkg::KIND_NONE);
    assign same_kind = active_reg && (kind_reg == kind_m) && (phase_reg != fhpe_pkg::PH_EXIT);

    assign pt_sum  = {1'b0, phase_time_reg} + (TIME_BITS+1)'(elapsed_delta);
    assign pt_sat  = pt_sum[TIME_BITS] ? TIME_MAX : pt_sum[TIME_BITS-1:0];
    assign pt_ext  = TW'(phase_time_reg);
    assign in_enter = (phase_reg == fhpe_pkg::PH_ENTER);
    assign dur_cur = in_enter ? lat_enter_reg : lat_exit_reg;
    assign reached = pt_ext >= TW'(dur_cur);
    assign pulse_on = !lat_rm_reg && (kind_reg == fhpe_pkg::KIND_VALID);

    assign prod_hi  = prod_reg[FRAC+LVL_W-1:FRAC];
    assign om       = fhpe_pkg::ONE_LVL - alpha_reg;
    assign hold_sum = (DUR_W+1)'(hold_time_reg) + (DUR_W+1)'(delta_reg);

    always_comb
    begin
        if (idx_reg >= SPAN3)
        begin
            quad    = 2'd3;
            rem_idx = idx_reg - SPAN3;
        end
        else if (idx_reg >= SPAN2)
        begin
            quad    = 2'd2;
            rem_idx = idx_reg - SPAN2;
        end
        else if (idx_reg >= SPAN1)
        begin
            quad    = 2'd1;
            rem_idx = idx_reg - SPAN1;
        end
        else
        begin
            quad    = 2'd0;
            rem_idx = idx_reg;
        end
    end

    assign rom_addr  = quad[0] ? (ROM_AW'(SINE_TABLE_DEPTH) - ROM_AW'(rem_idx)) :
                                 ROM_AW'(rem_idx);
    assign pulse_up  = {1'b0, fhpe_pkg::ONE_LVL} + {1'b0, rom_data};
    assign pulse_dn  = fhpe_pkg::ONE_LVL - rom_data;
    assign pulse_val = quad[1] ? {1'b0, pulse_dn[LVL_W-1:1]} : pulse_up[LVL_W:1];

    always_comb
    begin
        mul_a = om;
        mul_b = om;
        unique case (state_reg)
            S_MUL_A:
            begin
                mul_a = in_enter ? om : alpha_reg;
                mul_b = in_enter ? om : alpha_reg;
            end
            S_MUL_B:
            begin
                mul_a = in_enter ? prod_hi : start_amount_reg;
                mul_b = in_enter ? om : prod_hi;
            end
            S_MUL_C:
            begin
                mul_a = fhpe_pkg::ONE_LVL - start_amount_reg;
                mul_b = fhpe_pkg::ONE_LVL - prod_hi;
            end
            default:
            begin
                mul_a = om;
                mul_b = om;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = NUM_W'({pt_ext[DUR_W-1:0], {FRAC{1'b0}}});
        div_den   = dur_cur;
        unique case (state_reg)
            S_TICK:
            begin
                if (phase_reg == fhpe_pkg::PH_HOLD)
                begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(hold_sum);
                    div_den   = lat_period_reg;
                end
                else
                begin
                    div_start = !reached;
                end
            end
            S_MOD:
            begin
                div_start = div_done && pulse_on;
                div_num   = NUM_W'(div_rem) * NUM_W'(SPAN4);
                div_den   = lat_period_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign res_load = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next        = state_reg;
        cfg_enter_next    = cfg_enter_reg;
        cfg_exit_next     = cfg_exit_reg;
        cfg_period_next   = cfg_period_reg;
        cfg_rm_next       = cfg_rm_reg;
        lat_enter_next    = lat_enter_reg;
        lat_exit_next     = lat_exit_reg;
        lat_period_next   = lat_period_reg;
        lat_rm_next       = lat_rm_reg;
        phase_next        = phase_reg;
        active_next       = active_reg;
        kind_next         = kind_reg;
        phase_time_next   = phase_time_reg;
        hold_time_next    = hold_time_reg;
        start_amount_next = start_amount_reg;
        amount_next       = amount_reg;
        pulse_next        = pulse_reg;
        started_next      = started_reg;
        delta_next        = delta_reg;
        alpha_next        = alpha_reg;
        prod_next         = prod_reg;
        idx_next          = idx_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                fhpe_pkg::CFG_ENTER_TIME:     cfg_enter_next  = cfg_data;
                fhpe_pkg::CFG_EXIT_TIME:      cfg_exit_next   = cfg_data;
                fhpe_pkg::CFG_PULSE_PERIOD:   cfg_period_next = cfg_data;
                fhpe_pkg::CFG_REDUCED_MOTION: cfg_rm_next     = cfg_data[0];
                default:                      cfg_rm_next     = cfg_rm_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    started_next = 1'b0;
                    delta_next   = elapsed_delta;
                    state_next   = S_DONE;
                    if (do_exit)
                    begin
                        if (active_reg && phase_reg != fhpe_pkg::PH_EXIT)
                        begin
                            start_amount_next = amount_reg;
                            phase_time_next   = '0;
                            pulse_next        = '0;
                            phase_next        = fhpe_pkg::PH_EXIT;
                        end
                    end
                    else if (mode == fhpe_pkg::MODE_BEGIN)
                    begin
                        lat_enter_next  = (cfg_enter_reg == '0) ? DUR_W'(1) : cfg_enter_reg;
                        lat_exit_next   = (cfg_exit_reg == '0) ? DUR_W'(1) : cfg_exit_reg;
                        lat_period_next = (cfg_period_reg == '0) ? DUR_W'(1) : cfg_period_reg;
                        lat_rm_next     = cfg_rm_reg;
                        if (same_kind)
                        begin
                            if (cfg_rm_reg)
                            begin
                                amount_next     = fhpe_pkg::ONE_LVL;
                                pulse_next      = '0;
                                phase_next      = fhpe_pkg::PH_HOLD;
                                phase_time_next = '0;
                            end
                        end
                        else
                        begin
                            kind_next         = kind_m;
                            active_next       = 1'b1;
                            phase_time_next   = '0;
                            hold_time_next    = '0;
                            start_amount_next = cfg_rm_reg ? fhpe_pkg::ONE_LVL : amount_reg;
                            amount_next       = cfg_rm_reg ? fhpe_pkg::ONE_LVL : amount_reg;
                            pulse_next        = '0;
                            phase_next        = cfg_rm_reg ? fhpe_pkg::PH_HOLD :
                                                             fhpe_pkg::PH_ENTER;
                            started_next      = 1'b1;
                        end
                    end
                    else if (mode == fhpe_pkg::MODE_TICK && active_reg)
                    begin
                        phase_time_next = pt_sat;
                        state_next      = S_TICK;
                    end
                end
            end
            S_TICK:
            begin
                if (phase_reg == fhpe_pkg::PH_HOLD)
                begin
                    amount_next = fhpe_pkg::ONE_LVL;
                    state_next  = S_MOD;
                end
                else if (!reached)
                begin
                    state_next = S_ALPHA;
                end
                else if (in_enter)
                begin
                    amount_next     = fhpe_pkg::ONE_LVL;
                    phase_next      = fhpe_pkg::PH_HOLD;
                    phase_time_next = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    phase_next        = fhpe_pkg::PH_INACTIVE;
                    active_next       = 1'b0;
                    kind_next         = fhpe_pkg::KIND_NONE;
                    phase_time_next   = '0;
                    hold_time_next    = '0;
                    start_amount_next = '0;
                    amount_next       = '0;
                    pulse_next        = '0;
                    lat_rm_next       = 1'b0;
                    state_next        = S_DONE;
                end
            end
            S_ALPHA:
            begin
                if (div_done)
                begin
                    alpha_next = div_quot[LVL_W-1:0];
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = in_enter ? S_MUL_C : S_APPLY;
            end
            S_MUL_C:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                amount_next = in_enter ? (start_amount_reg + prod_hi) :
                                         (start_amount_reg - prod_hi);
                state_next  = S_DONE;
            end
            S_MOD:
            begin
                if (div_done)
                begin
                    hold_time_next = div_rem;
                    if (pulse_on)
                    begin
                        state_next = S_IDX;
                    end
                    else
                    begin
                        pulse_next = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_IDX:
            begin
                if (div_done)
                begin
                    idx_next   = div_quot[IDX_W-1:0];
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                state_next = S_PULSE;
            end
            S_PULSE:
            begin
                pulse_next = pulse_val;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cfg_enter_reg    <= fhpe_pkg::ENTER_TIME_RST;
            cfg_exit_reg     <= fhpe_pkg::EXIT_TIME_RST;
            cfg_period_reg   <= fhpe_pkg::PULSE_PERIOD_RST;
            cfg_rm_reg       <= 1'b0;
            lat_enter_reg    <= fhpe_pkg::ENTER_TIME_RST;
            lat_exit_reg     <= fhpe_pkg::EXIT_TIME_RST;
            lat_period_reg   <= fhpe_pkg::PULSE_PERIOD_RST;
            lat_rm_reg       <= 1'b0;
            phase_reg        <= fhpe_pkg::PH_INACTIVE;
            active_reg       <= 1'b0;
            kind_reg         <= fhpe_pkg::KIND_NONE;
            phase_time_reg   <= '0;
            hold_time_reg    <= '0;
            start_amount_reg <= '0;
            amount_reg       <= '0;
            pulse_reg        <= '0;
            started_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cfg_enter_reg    <= cfg_enter_next;
            cfg_exit_reg     <= cfg_exit_next;
            cfg_period_reg   <= cfg_period_next;
            cfg_rm_reg       <= cfg_rm_next;
            lat_enter_reg    <= lat_enter_next;
            lat_exit_reg     <= lat_exit_next;
            lat_period_reg   <= lat_period_next;
            lat_rm_reg       <= lat_rm_next;
            phase_reg        <= phase_next;
            active_reg       <= active_next;
            kind_reg         <= kind_next;
            phase_time_reg   <= phase_time_next;
            hold_time_reg    <= hold_time_next;
            start_amount_reg <= start_amount_next;
            amount_reg       <= amount_next;
            pulse_reg        <= pulse_next;
            started_reg      <= started_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        alpha_reg <= alpha_next;
        prod_reg  <= prod_next;
        idx_reg   <= idx_next;
        if (res_load)
        begin
            res_active_reg  <= active_reg;
            res_kind_reg    <= kind_reg;
            res_phase_reg   <= phase_reg;
            res_amount_reg  <= amount_reg;
            res_pulse_reg   <= pulse_reg;
            res_started_reg <= started_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign active       = res_active_reg;
    assign shown_kind   = res_kind_reg;
    assign phase        = res_phase_reg;
    assign amount       = res_amount_reg;
    assign pulse        = res_pulse_reg;
    assign started      = res_started_reg;

endmodule

/* test/fhpe_checker.sv */
// ----------------------------------------------------------------------------
// fhpe_checker: envelope predictor and result scoreboard
// Watches the item, result and register channels of the envelope. Keeps its
// own copy of the envelope state and registers, predicts one result for every
// accepted transaction and compares each accepted result, field by field,
// with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module fhpe_checker #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int TIME_BITS        = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic [1:0]                    mode,
    input  logic [1:0]                    kind,
    input  logic [fhpe_pkg::DELTA_W-1:0]  elapsed_delta,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic                          active,
    input  logic [1:0]                    shown_kind,
    input  logic [1:0]                    phase,
    input  fhpe_pkg::level_t              amount,
    input  fhpe_pkg::level_t              pulse,
    input  logic                          started,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [fhpe_pkg::DUR_W-1:0]    cfg_data,
    output int                            fails,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fhpe_pkg::*;

    localparam longint unsigned UNIT     = 64'd1 << FRAC_BITS;
    localparam longint unsigned TIME_TOP = (64'd1 << TIME_BITS) - 64'd1;

    typedef struct packed {
        logic   on;
        code_t  shown;
        code_t  ph;
        level_t lvl;
        level_t pls;
        logic   fresh;
    } env_view_t;

    longint unsigned quarter_sine [0:SINE_TABLE_DEPTH];
    env_view_t       due_views [$];
    env_view_t       view_now;
    env_view_t       view_due;

    dur_t            set_enter;
    dur_t            set_exit;
    dur_t            set_period;
    logic            set_calm;
    longint unsigned run_enter;
    longint unsigned run_exit;
    longint unsigned run_period;
    logic            run_calm;

    logic            env_on;
    code_t           env_phase;
    code_t           env_kind;
    code_t           item_kind;
    longint unsigned phase_us;
    longint unsigned hold_us;
    longint unsigned from_lvl;
    longint unsigned lvl;
    longint unsigned pls;

    function automatic longint unsigned taylor_sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        int unsigned     k;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        for (k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic longint unsigned ramp_alpha(input longint unsigned t,
                                                   input longint unsigned dur);
        if (t >= dur)
            return UNIT;
        return (t * UNIT) / dur;
    endfunction

    function automatic longint unsigned breathe_level(input longint unsigned h,
                                                      input longint unsigned period);
        longint unsigned idx;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned s;
        idx  = (h * 4 * SINE_TABLE_DEPTH) / period;
        quad = (idx / SINE_TABLE_DEPTH) % 4;
        r    = idx % SINE_TABLE_DEPTH;
        s    = (quad % 2 == 1) ? quarter_sine[SINE_TABLE_DEPTH - r] : quarter_sine[r];
        return (quad < 2) ? (UNIT + s) >> 1 : (UNIT - s) >> 1;
    endfunction

    function automatic longint unsigned at_least_one(input dur_t v);
        return (v == '0) ? 64'd1 : {40'd0, v};
    endfunction

    function automatic void clear_envelope();
        env_phase = PH_INACTIVE;
        env_on    = 1'b0;
        env_kind  = KIND_NONE;
        phase_us  = 0;
        hold_us   = 0;
        from_lvl  = 0;
        lvl       = 0;
        pls       = 0;
        run_calm  = 1'b0;
    endfunction

    function automatic void start_fade_out();
        if (!env_on || env_phase == PH_EXIT)
            return;
        from_lvl  = lvl;
        phase_us  = 0;
        pls       = 0;
        env_phase = PH_EXIT;
    endfunction

    function automatic logic open_kind(input code_t k);
        if (k == KIND_NONE)
        begin
            start_fade_out();
            return 1'b0;
        end
        run_enter  = at_least_one(set_enter);
        run_exit   = at_least_one(set_exit);
        run_period = at_least_one(set_period);
        run_calm   = set_calm;
        if (env_on && env_kind == k && env_phase != PH_EXIT)
        begin
            if (run_calm)
            begin
                lvl       = UNIT;
                pls       = 0;
                env_phase = PH_HOLD;
                phase_us  = 0;
            end
            return 1'b0;
        end
        env_kind  = k;
        env_on    = 1'b1;
        phase_us  = 0;
        hold_us   = 0;
        from_lvl  = run_calm ? UNIT : lvl;
        lvl       = from_lvl;
        pls       = 0;
        env_phase = run_calm ? PH_HOLD : PH_ENTER;
        return 1'b1;
    endfunction

    function automatic void advance_time(input longint unsigned delta);
        longint unsigned a;
        longint unsigned om;
        longint unsigned cube;
        longint unsigned sq;
        if (!env_on)
            return;
        phase_us = (phase_us + delta > TIME_TOP) ? TIME_TOP : phase_us + delta;
        case (env_phase)
            PH_ENTER:
            begin
                a    = ramp_alpha(phase_us, run_enter);
                om   = UNIT - a;
                cube = (((om * om) >> FRAC_BITS) * om) >> FRAC_BITS;
                lvl  = from_lvl + (((UNIT - from_lvl) * (UNIT - cube)) >> FRAC_BITS);
                if (a == UNIT)
                begin
                    lvl       = UNIT;
                    env_phase = PH_HOLD;
                    phase_us  = 0;
                end
            end
            PH_HOLD:
            begin
                lvl     = UNIT;
                hold_us = (hold_us + delta) % run_period;
                pls     = (run_calm || env_kind != KIND_VALID) ?
                          64'd0 : breathe_level(hold_us, run_period);
            end
            PH_EXIT:
            begin
                a   = ramp_alpha(phase_us, run_exit);
                sq  = (a * a) >> FRAC_BITS;
                lvl = from_lvl - ((from_lvl * sq) >> FRAC_BITS);
                if (a == UNIT)
                    clear_envelope();
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input longint unsigned due,
                               input longint unsigned seen);
        if (due != seen)
        begin
            fails++;
            $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, due, seen);
        end
    endtask

    initial
    begin
        int              i;
        longint unsigned s;
        for (i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            s = taylor_sine_q30((HALF_PI_Q30 * i) / SINE_TABLE_DEPTH);
            s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            quarter_sine[i] = (s > UNIT) ? UNIT : s;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_enter  = ENTER_TIME_RST;
            set_exit   = EXIT_TIME_RST;
            set_period = PULSE_PERIOD_RST;
            set_calm   = 1'b0;
            run_enter  = ENTER_TIME_RST;
            run_exit   = EXIT_TIME_RST;
            run_period = PULSE_PERIOD_RST;
            clear_envelope();
            due_views.delete();
            fails = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENTER_TIME:     set_enter  = cfg_data;
                    CFG_EXIT_TIME:      set_exit   = cfg_data;
                    CFG_PULSE_PERIOD:   set_period = cfg_data;
                    CFG_REDUCED_MOTION: set_calm   = cfg_data[0];
                    default: ;
                endcase
            end

            if (item_valid && !item_stall)
            begin
                item_kind      = (kind > KIND_OTHER) ? KIND_OTHER : kind;
                view_now.fresh = 1'b0;
                case (mode)
                    MODE_TICK:  advance_time(elapsed_delta);
                    MODE_BEGIN: view_now.fresh = open_kind(item_kind);
                    MODE_EXIT:  start_fade_out();
                    default: ;
                endcase
                view_now.on    = env_on;
                view_now.shown = env_kind;
                view_now.ph    = env_phase;
                view_now.lvl   = lvl[LVL_W-1:0];
                view_now.pls   = pls[LVL_W-1:0];
                due_views.push_back(view_now);
            end

            if (result_valid && !result_stall)
            begin
                if (due_views.size() == 0)
                begin
                    fails++;
                    $display("%0d ns: result with no transaction outstanding, amount %0d",
                             $time, amount);
                end
                else
                begin
                    view_due = due_views.pop_front();
                    check_field("active", view_due.on, active);
                    check_field("shown_kind", view_due.shown, shown_kind);
                    check_field("phase", view_due.ph, phase);
                    check_field("amount", view_due.lvl, amount);
                    check_field("pulse", view_due.pls, pulse);
                    check_field("started", view_due.fresh, started);
                end
            end

            pending <= due_views.size();
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top of the fade/hold/pulse envelope
// Drives directed and random transactions and register settings into the
// envelope with random source gaps and sink stalls, lets the checker predict
// and compare every result, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhpe_pkg::*;

    localparam code_t KIND_SPARE   = 2'd3;
    localparam int    SEGMENTS     = 17;
    localparam int    SEG_ITEMS    = 100;
    localparam int    QUIET_LIMIT  = 2000;
    localparam int    DRAIN_CYCLES = 64;
    localparam dur_t  DUR_TOP      = '1;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               item_valid    = 1'b0;
    logic               item_stall;
    code_t              mode          = MODE_TICK;
    code_t              kind          = KIND_NONE;
    logic [DELTA_W-1:0] elapsed_delta = '0;
    logic               result_valid;
    logic               result_stall  = 1'b0;
    logic               active;
    code_t              shown_kind;
    code_t              phase;
    level_t             amount;
    level_t             pulse;
    logic               started;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    code_t              cfg_index     = CFG_ENTER_TIME;
    dur_t               cfg_data      = '0;
    int                 fails;
    int                 pending;
    int                 items_sent    = 0;
    int                 quiet_cycles  = 0;
    logic               no_gaps       = 1'b0;

    fade_hold_pulse_envelope i_dut (.*);

    fhpe_checker i_checker (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int hold;
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    function automatic code_t any_code();
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [DELTA_W-1:0] any_delta();
        return $urandom_range(0, 65535);
    endfunction

    function automatic logic [DELTA_W-1:0] ease_delta(input int unsigned span);
        if ($urandom_range(0, 7) == 0)
            return '1;
        return $urandom_range(0, span);
    endfunction

    function automatic dur_t pick_duration();
        case ($urandom_range(0, 9))
            0:          return 24'd1;
            1:          return DUR_TOP;
            2, 3, 4:    return $urandom_range(1, 1000);
            5, 6, 7, 8: return $urandom_range(1000, 300000);
            default:    return $urandom_range(0, DUR_TOP);
        endcase
    endfunction

    // hold valid high after acceptance; the next call or the caller drops it
    task automatic send_item(input code_t m, input code_t k, input logic [DELTA_W-1:0] d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        mode          <= m;
        kind          <= k;
        elapsed_delta <= d;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input code_t idx, input dur_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input dur_t enter_us, input dur_t exit_us,
                                 input dur_t period_us, input logic calm);
        item_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_ENTER_TIME, enter_us);
        write_reg(CFG_EXIT_TIME, exit_us);
        write_reg(CFG_PULSE_PERIOD, period_us);
        write_reg(CFG_REDUCED_MOTION, {{(DUR_W-1){1'b0}}, calm});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          seg;
        int          stop_at;
        dur_t        enter_us;
        dur_t        exit_us;
        dur_t        period_us;
        logic        calm;
        int unsigned enter_span;
        int unsigned exit_span;
        code_t       k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_item(MODE_TICK, KIND_NONE, 16'hFFFF);
        send_item(MODE_EXIT, KIND_VALID, 16'h0000);
        send_item(MODE_IGNORE, KIND_SPARE, 16'h1234);
        send_item(MODE_BEGIN, KIND_SPARE, 16'h0000);
        send_item(MODE_BEGIN, KIND_OTHER, 16'hFFFF);
        send_item(MODE_TICK, KIND_OTHER, 16'h5555);
        send_item(MODE_TICK, KIND_OTHER, 16'hAAAA);
        repeat (3) send_item(MODE_TICK, KIND_NONE, 16'hFFFF);
        send_item(MODE_TICK, KIND_NONE, 16'd1000);
        send_item(MODE_BEGIN, KIND_VALID, 16'h0000);
        repeat (4) send_item(MODE_TICK, KIND_VALID, 16'hFFFF);
        send_item(MODE_TICK, KIND_VALID, 16'd12345);
        send_item(MODE_TICK, KIND_VALID, 16'd40000);
        send_item(MODE_BEGIN, KIND_NONE, 16'h0000);
        send_item(MODE_EXIT, KIND_NONE, 16'h0000);
        send_item(MODE_IGNORE, KIND_VALID, 16'hFFFF);
        repeat (3) send_item(MODE_TICK, KIND_NONE, 16'hFFFF);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:
                begin
                    enter_us  = '0;
                    exit_us   = '0;
                    period_us = '0;
                    calm      = 1'b1;
                end
                1:
                begin
                    enter_us  = 24'd1;
                    exit_us   = 24'd1;
                    period_us = 24'd1;
                    calm      = 1'b0;
                end
                2:
                begin
                    enter_us  = DUR_TOP;
                    exit_us   = 24'd1000;
                    period_us = DUR_TOP;
                    calm      = 1'b0;
                end
                default:
                begin
                    enter_us  = pick_duration();
                    exit_us   = pick_duration();
                    period_us = pick_duration();
                    calm      = ($urandom_range(0, 3) == 0);
                end
            endcase
            load_settings(enter_us, exit_us, period_us, calm);
            no_gaps = (seg > 2) && ($urandom_range(0, 3) == 0);

            if (seg == 2)
            begin
                // run the longest rise into time saturation, then breathe and fall
                send_item(MODE_BEGIN, KIND_VALID, any_delta());
                repeat (258) send_item(MODE_TICK, any_code(), 16'hFFFF);
                repeat (6) send_item(MODE_TICK, any_code(), any_delta());
                send_item(MODE_EXIT, any_code(), any_delta());
                repeat (2) send_item(MODE_TICK, any_code(), 16'd1000);
            end
            else
            begin
                enter_span = (enter_us / 3 + 1 > 65535) ? 65535 : enter_us / 3 + 1;
                exit_span  = (exit_us / 3 + 1 > 65535) ? 65535 : exit_us / 3 + 1;
                stop_at    = items_sent + SEG_ITEMS;
                while (items_sent < stop_at)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(any_code(), any_code(), any_delta());
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0:       k = KIND_SPARE;
                            1, 2, 3: k = KIND_OTHER;
                            default: k = KIND_VALID;
                        endcase
                        send_item(MODE_BEGIN, k, any_delta());
                        repeat ($urandom_range(1, 8))
                            send_item(MODE_TICK, any_code(), ease_delta(enter_span));
                        repeat ($urandom_range(0, 8))
                            send_item(MODE_TICK, any_code(), any_delta());
                        if ($urandom_range(0, 3) == 0)
                            send_item(MODE_BEGIN, $urandom_range(0, 1) ? k : KIND_VALID,
                                      any_delta());
                        if ($urandom_range(0, 1) == 1)
                            send_item(MODE_EXIT, any_code(), any_delta());
                        else
                            send_item(MODE_BEGIN, KIND_NONE, any_delta());
                        repeat ($urandom_range(1, 8))
                            send_item(MODE_TICK, any_code(), ease_delta(exit_span));
                    end
                end
            end
        end

        item_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
